[sv/sfcs_pkg.sv]
// sfcs_pkg: shared types, command and job codes, and the frame builder
// used by the front, queue and back modules of the flash command sequencer
// no dependencies
package sfcs_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] CMD_SECT_ERASE  = 4'd0;
  localparam logic [3:0] CMD_BLOCK_ERASE = 4'd1;
  localparam logic [3:0] CMD_CHIP_ERASE  = 4'd2;
  localparam logic [3:0] CMD_PROG_FIRST  = 4'd3;
  localparam logic [3:0] CMD_PROG_NEXT   = 4'd4;
  localparam logic [3:0] CMD_PROG_END    = 4'd5;
  localparam logic [3:0] CMD_READ_START  = 4'd6;
  localparam logic [3:0] CMD_READ_NEXT   = 4'd7;
  localparam logic [3:0] CMD_READ_END    = 4'd8;
  localparam logic [3:0] CMD_READ_ID     = 4'd9;
  localparam logic [3:0] CMD_WRITE_STAT  = 4'd10;
  localparam logic [3:0] CMD_INIT        = 4'd11;

  localparam logic [7:0] OP_AAI   = 8'hAF;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_EWRSR = 8'h50;
  localparam logic [7:0] OP_WRSR  = 8'h01;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_RDID  = 8'h90;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_BE    = 8'h52;
  localparam logic [7:0] OP_CE    = 8'h60;
  localparam logic [7:0] DUMMY    = 8'hA5;

  localparam logic [3:0] JOB_REJECT   = 4'd0;
  localparam logic [3:0] JOB_ERASE    = 4'd1;
  localparam logic [3:0] JOB_CHIP     = 4'd2;
  localparam logic [3:0] JOB_PFIRST   = 4'd3;
  localparam logic [3:0] JOB_PNEXT    = 4'd4;
  localparam logic [3:0] JOB_WRDIPOLL = 4'd5;
  localparam logic [3:0] JOB_RSTART   = 4'd6;
  localparam logic [3:0] JOB_DUMMY    = 4'd7;
  localparam logic [3:0] JOB_RELDONE  = 4'd8;
  localparam logic [3:0] JOB_ID       = 4'd9;
  localparam logic [3:0] JOB_WRSR     = 4'd10;
  localparam logic [3:0] JOB_POLLUNP  = 4'd11;
  localparam logic [3:0] JOB_RDBYTE   = 4'd12;
  localparam logic [3:0] JOB_IDDONE   = 4'd13;

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] addr;
    logic [15:0] aux;
  } job_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        select_before;
    logic        release_after;
    logic        want_reply;
    logic        host_valid;
    logic [15:0] host_data;
    logic        done_res;
    logic        rejected;
    logic        last;
  } item_t;

  function automatic item_t mk_frame(logic [7:0] b, logic sel, logic rel);
    item_t it;
    it = '0;
    it.tx_valid      = 1'b1;
    it.tx_byte       = b;
    it.select_before = sel;
    it.release_after = rel;
    return it;
  endfunction

  function automatic item_t mk_dummy();
    item_t it;
    it = mk_frame(DUMMY, 1'b0, 1'b0);
    it.want_reply = 1'b1;
    it.last       = 1'b1;
    return it;
  endfunction

  // one word of a job, chosen by its step
  function automatic item_t build_item(job_t j, logic [2:0] step);
    item_t it;
    it = '0;
    case (j.kind)
      JOB_ERASE: begin
        case (step)
          3'd0: it = mk_frame(OP_WREN, 1'b1, 1'b1);
          3'd1: it = mk_frame(j.aux[7:0], 1'b1, 1'b0);
          3'd2: it = mk_frame(j.addr[23:16], 1'b0, 1'b0);
          3'd3: it = mk_frame(j.addr[15:8], 1'b0, 1'b0);
          3'd4: it = mk_frame(j.addr[7:0], 1'b0, 1'b1);
          3'd5: it = mk_frame(OP_RDSR, 1'b1, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_CHIP: begin
        case (step)
          3'd0: it = mk_frame(OP_WREN, 1'b1, 1'b1);
          3'd1: it = mk_frame(OP_CE, 1'b1, 1'b1);
          3'd2: it = mk_frame(OP_RDSR, 1'b1, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_PFIRST: begin
        case (step)
          3'd0: it = mk_frame(OP_WREN, 1'b1, 1'b1);
          3'd1: it = mk_frame(OP_AAI, 1'b1, 1'b0);
          3'd2: it = mk_frame(j.addr[23:16], 1'b0, 1'b0);
          3'd3: it = mk_frame(j.addr[15:8], 1'b0, 1'b0);
          3'd4: it = mk_frame(j.addr[7:0], 1'b0, 1'b0);
          3'd5: it = mk_frame(j.aux[7:0], 1'b0, 1'b1);
          3'd6: it = mk_frame(OP_RDSR, 1'b1, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_PNEXT: begin
        case (step)
          3'd0: it = mk_frame(OP_AAI, 1'b1, 1'b0);
          3'd1: it = mk_frame(j.aux[7:0], 1'b0, 1'b1);
          3'd2: it = mk_frame(OP_RDSR, 1'b1, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_WRDIPOLL: begin
        case (step)
          3'd0: it = mk_frame(OP_WRDI, 1'b1, 1'b1);
          3'd1: it = mk_frame(OP_RDSR, 1'b1, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_RSTART: begin
        case (step)
          3'd0: it = mk_frame(OP_READ, 1'b1, 1'b0);
          3'd1: it = mk_frame(j.addr[23:16], 1'b0, 1'b0);
          3'd2: it = mk_frame(j.addr[15:8], 1'b0, 1'b0);
          default: begin
            it = mk_frame(j.addr[7:0], 1'b0, 1'b0);
            it.done_res = 1'b1;
            it.last     = 1'b1;
          end
        endcase
      end
      JOB_DUMMY: it = mk_dummy();
      JOB_RELDONE: begin
        it.release_after = 1'b1;
        it.done_res      = 1'b1;
        it.last          = 1'b1;
      end
      JOB_ID: begin
        case (step)
          3'd0: it = mk_frame(OP_RDID, 1'b1, 1'b0);
          3'd1, 3'd2, 3'd3: it = mk_frame(8'h00, 1'b0, 1'b0);
          default: it = mk_dummy();
        endcase
      end
      JOB_WRSR: begin
        case (step)
          3'd0: it = mk_frame(OP_EWRSR, 1'b1, 1'b1);
          3'd1: it = mk_frame(OP_WRSR, 1'b1, 1'b0);
          default: begin
            it = mk_frame(j.aux[7:0], 1'b0, 1'b1);
            it.done_res = 1'b1;
            it.last     = 1'b1;
          end
        endcase
      end
      JOB_POLLUNP: begin
        case (step)
          3'd0: it.release_after = 1'b1;
          3'd1: it = mk_frame(OP_EWRSR, 1'b1, 1'b1);
          3'd2: it = mk_frame(OP_WRSR, 1'b1, 1'b0);
          default: begin
            it = mk_frame(8'h00, 1'b0, 1'b1);
            it.done_res = 1'b1;
            it.last     = 1'b1;
          end
        endcase
      end
      JOB_RDBYTE: begin
        it.host_valid = 1'b1;
        it.host_data  = j.aux;
        it.done_res   = 1'b1;
        it.last       = 1'b1;
      end
      JOB_IDDONE: begin
        it.release_after = 1'b1;
        it.host_valid    = 1'b1;
        it.host_data     = j.aux;
        it.done_res      = 1'b1;
        it.last          = 1'b1;
      end
      default: begin
        it.rejected = 1'b1;
        it.last     = 1'b1;
      end
    endcase
    return it;
  endfunction

endpackage

[sv/spi_flash_command_sequencer_unit.sv]
// spi_flash_command_sequencer_unit: top level of the serial flash sequencer
// built from sfcs_front, sfcs_queue and sfcs_back; uses sfcs_pkg
//
// usage
// - input channel (in_*): host commands (in_opcode 0) and bytes returned by the
//   flash for the last transfer that asked for one (in_opcode 1)
// - output channel (out_*): byte frames with select and release marks, host
//   read data and ID, done and reject flags; out_last marks the final word
//   caused by one input word
// - an input word is taken whenever the job queue has room; the state update
//   happens at the edge that takes it, so words may arrive back to back
// - the back end emits one output word per cycle unless the receiver stalls;
//   an input word expands to 0 to 8 output words (none for a stray flash byte)
// - an accepted input passes through the job queue, then the output register
// - when the receiver stalls the output register holds its word and the
//   queue fills; in_ready drops once QUEUE_DEPTH jobs are waiting
// - reset (rst_n low, synchronous) empties the queue and output register and
//   returns the sequencer to idle with no read session open
module spi_flash_command_sequencer_unit import sfcs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_command,
  input  logic [23:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_reply_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_select_before,
  output logic        out_release_after,
  output logic        out_want_reply,
  output logic        out_host_valid,
  output logic [15:0] out_host_data,
  output logic        out_done_res,
  output logic        out_rejected,
  output logic        out_last
);

  logic  q_full, push, pop, head_valid;
  job_t  push_job, head_job;
  item_t out_item;

  sfcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_data_byte  (in_data_byte),
    .in_reply_byte (in_reply_byte),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  sfcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  assign out_tx_valid      = out_item.tx_valid;
  assign out_tx_byte       = out_item.tx_byte;
  assign out_select_before = out_item.select_before;
  assign out_release_after = out_item.release_after;
  assign out_want_reply    = out_item.want_reply;
  assign out_host_valid    = out_item.host_valid;
  assign out_host_data     = out_item.host_data;
  assign out_done_res      = out_item.done_res;
  assign out_rejected      = out_item.rejected;
  assign out_last          = out_item.last;

endmodule

[sv/sfcs_front.sv]
// sfcs_front: accepts host commands and flash replies, tracks the sequencer
// state and turns each command and each awaited flash reply into a job for the back end; uses sfcs_pkg
module sfcs_front import sfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_command,
  input  logic [23:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_reply_byte,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_POLL = 3'd1;
  localparam logic [2:0] PH_READ = 3'd2;
  localparam logic [2:0] PH_IDHI = 3'd3;
  localparam logic [2:0] PH_IDLO = 3'd4;

  localparam logic [1:0] AP_FINISH    = 2'd0;
  localparam logic [1:0] AP_UNPROTECT = 2'd1;

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] after_poll_r, after_poll_nxt;
  logic       rso_r, rso_nxt;
  logic [7:0] id_hi_r, id_hi_nxt;
  logic       acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_nxt      = phase_r;
    after_poll_nxt = after_poll_r;
    rso_nxt        = rso_r;
    id_hi_nxt      = id_hi_r;
    push           = 1'b0;
    push_job       = '0;
    push_job.addr  = in_address;
    push_job.aux   = {8'h00, in_data_byte};
    if (acc) begin
      if (in_opcode) begin
        case (phase_r)
          PH_POLL: begin
            push = 1'b1;
            if (in_reply_byte[0]) begin
              push_job.kind = JOB_DUMMY;
            end else begin
              phase_nxt      = PH_IDLE;
              after_poll_nxt = AP_FINISH;
              push_job.kind  = (after_poll_r == AP_UNPROTECT) ? JOB_POLLUNP : JOB_RELDONE;
            end
          end
          PH_READ: begin
            push          = 1'b1;
            push_job.kind = JOB_RDBYTE;
            push_job.aux  = {8'h00, in_reply_byte};
            phase_nxt     = PH_IDLE;
          end
          PH_IDHI: begin
            push          = 1'b1;
            push_job.kind = JOB_DUMMY;
            id_hi_nxt     = in_reply_byte;
            phase_nxt     = PH_IDLO;
          end
          PH_IDLO: begin
            push          = 1'b1;
            push_job.kind = JOB_IDDONE;
            push_job.aux  = {id_hi_r, in_reply_byte};
            phase_nxt     = PH_IDLE;
          end
          default: push = 1'b0;
        endcase
      end else begin
        push          = 1'b1;
        push_job.kind = JOB_REJECT;
        if (phase_r == PH_IDLE && in_command <= CMD_INIT &&
            (!rso_r || in_command == CMD_READ_NEXT || in_command == CMD_READ_END)) begin
          case (in_command)
            CMD_SECT_ERASE, CMD_BLOCK_ERASE: begin
              push_job.kind = JOB_ERASE;
              push_job.aux  = {8'h00, (in_command == CMD_SECT_ERASE) ? OP_SE : OP_BE};
              phase_nxt     = PH_POLL;
              after_poll_nxt = AP_FINISH;
            end
            CMD_CHIP_ERASE: begin
              push_job.kind  = JOB_CHIP;
              phase_nxt      = PH_POLL;
              after_poll_nxt = AP_FINISH;
            end
            CMD_PROG_FIRST: begin
              push_job.kind  = JOB_PFIRST;
              phase_nxt      = PH_POLL;
              after_poll_nxt = AP_FINISH;
            end
            CMD_PROG_NEXT: begin
              push_job.kind  = JOB_PNEXT;
              phase_nxt      = PH_POLL;
              after_poll_nxt = AP_FINISH;
            end
            CMD_PROG_END: begin
              push_job.kind  = JOB_WRDIPOLL;
              phase_nxt      = PH_POLL;
              after_poll_nxt = AP_FINISH;
            end
            CMD_READ_START: begin
              push_job.kind = JOB_RSTART;
              rso_nxt       = 1'b1;
            end
            CMD_READ_NEXT: begin
              if (rso_r) begin
                push_job.kind = JOB_DUMMY;
                phase_nxt     = PH_READ;
              end
            end
            CMD_READ_END: begin
              if (rso_r) begin
                push_job.kind = JOB_RELDONE;
                rso_nxt       = 1'b0;
              end
            end
            CMD_READ_ID: begin
              push_job.kind = JOB_ID;
              phase_nxt     = PH_IDHI;
            end
            CMD_WRITE_STAT: push_job.kind = JOB_WRSR;
            CMD_INIT: begin
              push_job.kind  = JOB_WRDIPOLL;
              phase_nxt      = PH_POLL;
              after_poll_nxt = AP_UNPROTECT;
            end
            default: push_job.kind = JOB_REJECT;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      after_poll_r <= AP_FINISH;
      rso_r        <= 1'b0;
      id_hi_r      <= 8'h00;
    end else begin
      phase_r      <= phase_nxt;
      after_poll_r <= after_poll_nxt;
      rso_r        <= rso_nxt;
      id_hi_r      <= id_hi_nxt;
    end
  end

endmodule

[sv/sfcs_queue.sv]
// sfcs_queue: short job queue between the front and back ends
// uses sfcs_pkg for the job type
module sfcs_queue import sfcs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[sv/sfcs_back.sv]
// sfcs_back: steps the head job into the output register one word per cycle
// unless stalled; uses sfcs_pkg for the job and word types and the frame builder
module sfcs_back import sfcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  job_t head_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output item_t out_item
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  item_t      item_r;
  item_t      item_c;
  logic       fire;

  assign item_c    = build_item(head_job, step_r);
  assign fire      = head_valid && (!out_valid_r || out_ready);
  assign pop       = fire && item_c.last;
  assign out_valid = out_valid_r;
  assign out_item  = item_r;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      step_nxt      = item_c.last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item_r <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/sfcs_checker.sv]
// sfcs_checker: port-level assertions for the flash command sequencer
// bound to spi_flash_command_sequencer_unit; uses sfcs_pkg
module sfcs_checker import sfcs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_byte,
  input logic        out_want_reply,
  input logic        out_host_valid,
  input logic        out_done_res,
  input logic        out_rejected,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_last && !out_tx_valid && !out_done_res)
    else $error("reject word not alone");

  a_host_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_host_valid |-> out_done_res && out_last && !out_tx_valid)
    else $error("host data word malformed");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_want_reply |-> out_tx_valid && out_last && out_tx_byte == DUMMY)
    else $error("reply request not a final dummy word");

endmodule

bind spi_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_tx_valid   (out_tx_valid),
  .out_tx_byte    (out_tx_byte),
  .out_want_reply (out_want_reply),
  .out_host_valid (out_host_valid),
  .out_done_res   (out_done_res),
  .out_rejected   (out_rejected),
  .out_last       (out_last)
);
